/* hw/rtl/avr_pkg.sv */
// types and constants shared by the valley rotation detector
`default_nettype none

package avr_pkg;

    localparam logic [15:0] INTERVAL_RESET = 16'd10;

    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_CLEAR = 1'b1
    } t_func;

    typedef struct packed {
        t_func              func;
        logic signed [15:0] accel_sample;
    } t_in_item;

    typedef struct packed {
        logic               rotation_flag;
        logic [31:0]        valley_interval_ms;
        logic               sampled;
        logic signed [15:0] smoothed_slope;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] delta;
        logic signed [15:0] avg;
        logic               valley;
    } t_slope_res;

endpackage

`default_nettype wire

/* hw/rtl/avr_slope.sv */
// slope datapath: first difference, extrapolated slope, averaging, valley test
`default_nettype none

module avr_slope (
    input  wire logic signed [15:0] i_sample,
    input  wire logic signed [15:0] i_prev_sample,
    input  wire logic signed [15:0] i_prev_delta,
    input  wire logic signed [15:0] i_prev_slope,
    output avr_pkg::t_slope_res     o_res
);

    logic signed [15:0] w_d0;
    logic signed [18:0] w_d0_ext;
    logic signed [18:0] w_d1_ext;
    logic signed [18:0] w_x;
    logic signed [18:0] w_xa;
    logic signed [15:0] w_slope;
    logic signed [16:0] w_s;
    logic signed [16:0] w_sa;
    logic signed [15:0] w_avg;

    assign w_d0     = i_sample - i_prev_sample;
    assign w_d0_ext = {{3{w_d0[15]}}, w_d0};
    assign w_d1_ext = {{3{i_prev_delta[15]}}, i_prev_delta};
    assign w_x      = (w_d0_ext <<< 1) + w_d0_ext - w_d1_ext;
    // add one before halving a negative value so the result truncates toward zero
    assign w_xa     = w_x + $signed({18'b0, w_x[18]});
    assign w_slope  = w_xa[16:1];

    assign w_s      = {w_slope[15], w_slope} + {i_prev_slope[15], i_prev_slope};
    assign w_sa     = w_s + $signed({16'b0, w_s[16]});
    assign w_avg    = w_sa[16:1];

    assign o_res.delta  = w_d0;
    assign o_res.avg    = w_avg;
    assign o_res.valley = i_prev_slope[15] && !w_avg[15] && (w_avg != 16'sd0);

endmodule

`default_nettype wire

/* hw/rtl/accel_valley_rotation_detector.sv */
// result path: the input register, then the result register; an output stall can hold either
// throughput: one item per cycle while the output is not stalled; the state update sits between the two registers
// the result register stalls the input register only when both are full and stalled
// synchronous active-low reset clears all state but the payload registers, and the handshake; interval resets to 10
// the configuration port is always ready
`default_nettype none

module accel_valley_rotation_detector (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire avr_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output avr_pkg::t_out_item      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [15:0]        i_cfg_data
);

    logic [15:0]        r_interval;
    logic               r_in_valid;
    avr_pkg::t_in_item  r_in;
    logic               r_out_valid;
    avr_pkg::t_out_item r_out;

    logic [31:0]        r_time;
    logic [31:0]        r_last_sample;
    logic [31:0]        r_last_valley;
    logic [31:0]        r_valley_int;
    logic signed [15:0] r_prev_sample;
    logic signed [15:0] r_prev_delta;
    logic signed [15:0] r_prev_slope;
    logic               r_flag;

    logic [31:0]        n_time;
    logic [31:0]        n_last_sample;
    logic [31:0]        n_last_valley;
    logic [31:0]        n_valley_int;
    logic signed [15:0] n_prev_sample;
    logic signed [15:0] n_prev_delta;
    logic signed [15:0] n_prev_slope;
    logic               n_flag;
    logic               n_sampled;

    logic               w_out_adv;
    logic               w_work;
    logic               w_in_take;
    logic [31:0]        w_time_inc;
    logic [31:0]        w_elapsed;
    avr_pkg::t_slope_res w_res;

    assign o_cfg_ready = 1'b1;

    assign w_out_adv  = !r_out_valid || !i_out_stall;
    assign w_work     = r_in_valid && w_out_adv;
    assign o_in_stall = r_in_valid && !w_out_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    assign w_time_inc = r_time + 32'd1;
    assign w_elapsed  = w_time_inc - r_last_sample;

    avr_slope u_slope (
        .i_sample      (r_in.accel_sample),
        .i_prev_sample (r_prev_sample),
        .i_prev_delta  (r_prev_delta),
        .i_prev_slope  (r_prev_slope),
        .o_res         (w_res)
    );

    always_comb begin
        n_time        = r_time;
        n_last_sample = r_last_sample;
        n_last_valley = r_last_valley;
        n_valley_int  = r_valley_int;
        n_prev_sample = r_prev_sample;
        n_prev_delta  = r_prev_delta;
        n_prev_slope  = r_prev_slope;
        n_flag        = r_flag;
        n_sampled     = 1'b0;
        case (r_in.func)
            avr_pkg::FUNC_CLEAR: begin
                n_flag = 1'b0;
            end
            avr_pkg::FUNC_TICK: begin
                n_time = w_time_inc;
                if (w_elapsed > {16'b0, r_interval}) begin
                    n_sampled     = 1'b1;
                    n_prev_delta  = w_res.delta;
                    n_prev_sample = r_in.accel_sample;
                    n_prev_slope  = w_res.avg;
                    n_last_sample = w_time_inc;
                    if (w_res.valley) begin
                        n_valley_int  = w_time_inc - r_last_valley;
                        n_last_valley = w_time_inc;
                        n_flag        = 1'b1;
                    end
                end
            end
            default: begin
                n_flag = r_flag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval    <= avr_pkg::INTERVAL_RESET;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_time        <= '0;
            r_last_sample <= '0;
            r_last_valley <= '0;
            r_valley_int  <= '0;
            r_prev_sample <= '0;
            r_prev_delta  <= '0;
            r_prev_slope  <= '0;
            r_flag        <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_interval <= i_cfg_data;
            end
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_work) begin
                r_in_valid <= 1'b0;
            end
            if (w_work) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_work) begin
                r_time        <= n_time;
                r_last_sample <= n_last_sample;
                r_last_valley <= n_last_valley;
                r_valley_int  <= n_valley_int;
                r_prev_sample <= n_prev_sample;
                r_prev_delta  <= n_prev_delta;
                r_prev_slope  <= n_prev_slope;
                r_flag        <= n_flag;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_data;
        end
        if (w_work) begin
            r_out.rotation_flag      <= n_flag;
            r_out.valley_interval_ms <= n_valley_int;
            r_out.sampled            <= n_sampled;
            r_out.smoothed_slope     <= n_prev_slope;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_time_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_time)) |-> (r_time == $past(r_time) + 32'd1))
        else $error("millisecond count moved by other than one");

    a_sample_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_last_sample)) |-> (r_last_sample == r_time))
        else $error("sampling time differs from current time");

    a_flag_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_flag)) |->
            ($past(w_work) && ($past(r_in.func) == avr_pkg::FUNC_TICK)))
        else $error("rotation flag set without a tick");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled while the pipeline can move");

endmodule

`default_nettype wire
